>>> rtl/core/ifr_pkg.sv
`default_nettype none
package ifr_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FLAG      = 3'd0;
    localparam logic [2:0] REG_ESCAPE    = 3'd1;
    localparam logic [2:0] REG_ADDRESS   = 3'd2;
    localparam logic [2:0] REG_SEQ_ZERO  = 3'd3;
    localparam logic [2:0] REG_SEQ_MASK  = 3'd4;
    localparam logic [2:0] REG_START     = 3'd5;
    localparam logic [2:0] REG_END       = 3'd6;
    localparam logic [2:0] REG_INFO      = 3'd7;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // Register reset values
    localparam logic [7:0] RST_FLAG     = 8'h7E;
    localparam logic [7:0] RST_ESCAPE   = 8'h7D;
    localparam logic [7:0] RST_ADDRESS  = 8'h03;
    localparam logic [7:0] RST_SEQ_ZERO = 8'h00;
    localparam logic [7:0] RST_SEQ_MASK = 8'h40;
    localparam logic [7:0] RST_START    = 8'h02;
    localparam logic [7:0] RST_END      = 8'h03;
    localparam logic [7:0] RST_INFO     = 8'h01;

    // Byte stuffing transform
    localparam logic [7:0] STUFF_XOR = 8'h20;

    // Frame status codes
    localparam logic [1:0] STATUS_NEW   = 2'd0;
    localparam logic [1:0] STATUS_DUP   = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // Packet kind codes
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_INFO  = 2'd2;

    // Result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] address_byte;
        logic [7:0] seq_zero_control;
        logic [7:0] seq_toggle_mask;
        logic [7:0] start_type;
        logic [7:0] end_type;
        logic [7:0] info_type;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       data_valid;
        logic       frame_done;
        logic [1:0] frame_status;
        logic [1:0] packet_kind;
        logic       reply_reject;
        logic       reply_number;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/info_frame_receiver.sv
// Path: an accepted byte is held in the input register, parsed combinationally and
//   written into the result queue, whose head entry drives the outputs.
// Throughput: one byte per cycle while the queue has room for two results; a lone
//   escape gives two results, and the four-entry result queue absorbs the burst.
// Reset: synchronous active-low i_rst_n clears parse state, queue and config
//   registers (to their default values); no clearing pass is needed.
`default_nettype none
module info_frame_receiver
    import ifr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               i_rx_valid,
    output logic                    o_rx_ready,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_data_valid,
    output logic                    o_frame_done,
    output logic [1:0]              o_frame_status,
    output logic [1:0]              o_packet_kind,
    output logic                    o_reply_reject,
    output logic                    o_reply_number,
    output logic                    o_last
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       fire;
    t_result    res0, res1, res_out;
    logic [1:0] res_cnt;

    ifr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: moves on when the queue has room for two results
    assign fire       = r_in_valid & room;
    assign o_rx_ready = ~r_in_valid | room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) r_in_byte <= i_rx_byte;
    end

    ifr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_cnt)
    );

    ifr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_count (res_cnt),
        .o_room  (room),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_res   (res_out)
    );

    assign o_out_byte     = res_out.out_byte;
    assign o_data_valid   = res_out.data_valid;
    assign o_frame_done   = res_out.frame_done;
    assign o_frame_status = res_out.frame_status;
    assign o_packet_kind  = res_out.packet_kind;
    assign o_reply_reject = res_out.reply_reject;
    assign o_reply_number = res_out.reply_number;
    assign o_last         = res_out.last;

endmodule
`default_nettype wire

>>> rtl/core/ifr_cfg_regs.sv
`default_nettype none
module ifr_cfg_regs
    import ifr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [7:0] wr_val;
    logic [7:0] rd_val;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_val  = pwdata[7:0];
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte        <= RST_FLAG;
            r_cfg.escape_byte      <= RST_ESCAPE;
            r_cfg.address_byte     <= RST_ADDRESS;
            r_cfg.seq_zero_control <= RST_SEQ_ZERO;
            r_cfg.seq_toggle_mask  <= RST_SEQ_MASK;
            r_cfg.start_type       <= RST_START;
            r_cfg.end_type         <= RST_END;
            r_cfg.info_type        <= RST_INFO;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FLAG:     r_cfg.flag_byte        <= wr_val;
                REG_ESCAPE:   r_cfg.escape_byte      <= wr_val;
                REG_ADDRESS:  r_cfg.address_byte     <= wr_val;
                REG_SEQ_ZERO: r_cfg.seq_zero_control <= wr_val;
                REG_SEQ_MASK: r_cfg.seq_toggle_mask  <= wr_val;
                REG_START:    r_cfg.start_type       <= wr_val;
                REG_END:      r_cfg.end_type         <= wr_val;
                REG_INFO:     r_cfg.info_type        <= wr_val;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_FLAG:     rd_val = r_cfg.flag_byte;
            REG_ESCAPE:   rd_val = r_cfg.escape_byte;
            REG_ADDRESS:  rd_val = r_cfg.address_byte;
            REG_SEQ_ZERO: rd_val = r_cfg.seq_zero_control;
            REG_SEQ_MASK: rd_val = r_cfg.seq_toggle_mask;
            REG_START:    rd_val = r_cfg.start_type;
            REG_END:      rd_val = r_cfg.end_type;
            REG_INFO:     rd_val = r_cfg.info_type;
            default:      rd_val = 8'h00;
        endcase
    end

    assign prdata = {{(PDATA_W-8){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

>>> rtl/core/ifr_parser.sv
`default_nettype none
module ifr_parser
    import ifr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_result         o_res0,
    output t_result         o_res1,
    output logic [1:0]      o_count
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_FLAG    = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_CTRL    = 3'd3;
    localparam logic [2:0] PH_HDR_OK  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0] r_phase,  n_phase;
    logic       r_exp,    n_exp;
    logic       r_dup,    n_dup;
    logic       r_rej,    n_rej;
    logic       r_esc,    n_esc;
    logic [7:0] r_check,  n_check;
    logic [1:0] r_kind,   n_kind;

    logic [7:0] ctl_exp;
    logic [7:0] ctl_prev;
    logic [7:0] ctl_hdr;
    logic       is_flag;
    logic       is_type;
    t_result    res0, res1;
    logic [1:0] cnt;

    assign ctl_exp  = i_cfg.seq_zero_control ^ (r_exp ? i_cfg.seq_toggle_mask : 8'h00);
    assign ctl_prev = i_cfg.seq_zero_control ^ (r_exp ? 8'h00 : i_cfg.seq_toggle_mask);
    assign ctl_hdr  = i_cfg.address_byte ^ (r_dup ? ctl_prev : ctl_exp);
    assign is_flag  = (i_byte == i_cfg.flag_byte);
    assign is_type  = (i_byte == i_cfg.start_type) || (i_byte == i_cfg.end_type)
                   || (i_byte == i_cfg.info_type);

    // Next state and results for one byte
    always_comb begin
        n_phase = r_phase;
        n_exp   = r_exp;
        n_dup   = r_dup;
        n_rej   = r_rej;
        n_esc   = r_esc;
        n_check = r_check;
        n_kind  = r_kind;
        res0    = '0;
        res1    = '0;
        cnt     = 2'd0;

        case (r_phase)
            PH_FLAG: begin
                if (i_byte == i_cfg.address_byte) begin
                    n_phase = PH_ADDR;
                    n_dup   = 1'b0;
                end else if (!is_flag) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_ADDR: begin
                if (i_byte == ctl_exp) begin
                    n_dup   = 1'b0;
                    n_phase = PH_CTRL;
                end else if (i_byte == ctl_prev) begin
                    n_dup   = 1'b1;
                    n_phase = PH_CTRL;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CTRL: begin
                if (i_byte == ctl_hdr) n_phase = PH_HDR_OK;
                else if (is_flag)      n_phase = PH_FLAG;
                else                   n_phase = PH_IDLE;
            end
            PH_HDR_OK: begin
                if (is_type) begin
                    if (i_byte == i_cfg.start_type)    n_kind = KIND_START;
                    else if (i_byte == i_cfg.end_type) n_kind = KIND_END;
                    else                               n_kind = KIND_INFO;
                    n_check          = i_byte;
                    n_esc            = 1'b0;
                    n_phase          = PH_PAYLOAD;
                    res0.out_byte    = i_byte;
                    res0.data_valid  = 1'b1;
                    cnt              = 2'd1;
                end else if (is_flag) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                if (r_esc) begin
                    // byte after an escape: stuffed flag, stuffed escape or lone escape
                    n_esc           = 1'b0;
                    res0.data_valid = 1'b1;
                    cnt             = 2'd1;
                    if (i_byte == (i_cfg.flag_byte ^ STUFF_XOR)) begin
                        n_check       = r_check ^ i_cfg.flag_byte;
                        res0.out_byte = i_cfg.flag_byte;
                    end else if (i_byte == (i_cfg.escape_byte ^ STUFF_XOR)) begin
                        n_check       = r_check ^ i_cfg.escape_byte;
                        res0.out_byte = i_cfg.escape_byte;
                    end else begin
                        n_check         = r_check ^ i_cfg.escape_byte ^ i_byte;
                        res0.out_byte   = i_cfg.escape_byte;
                        res1.out_byte   = i_byte;
                        res1.data_valid = 1'b1;
                        cnt             = 2'd2;
                    end
                end else if (is_flag) begin
                    // closing flag
                    res0.frame_done = 1'b1;
                    cnt             = 2'd1;
                    n_phase         = PH_IDLE;
                    if (r_check == 8'h00) begin
                        n_rej = 1'b0;
                        if (r_dup && !r_rej) begin
                            res0.frame_status = STATUS_DUP;
                        end else begin
                            n_dup             = 1'b0;
                            n_exp             = ~r_exp;
                            res0.frame_status = STATUS_NEW;
                        end
                    end else begin
                        n_rej             = 1'b1;
                        res0.frame_status = STATUS_ERROR;
                        res0.reply_reject = 1'b1;
                    end
                    res0.reply_number = n_exp;
                end else if (i_byte == i_cfg.escape_byte) begin
                    n_esc = 1'b1;
                end else begin
                    n_check         = r_check ^ i_byte;
                    res0.out_byte   = i_byte;
                    res0.data_valid = 1'b1;
                    cnt             = 2'd1;
                end
            end
            default: begin
                n_phase = is_flag ? PH_FLAG : PH_IDLE;
            end
        endcase

        res0.packet_kind = n_kind;
        res1.packet_kind = n_kind;
        res0.last        = (cnt == 2'd1);
        res1.last        = (cnt == 2'd2);
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_exp   <= 1'b0;
            r_dup   <= 1'b0;
            r_rej   <= 1'b0;
            r_esc   <= 1'b0;
            r_check <= 8'h00;
            r_kind  <= KIND_START;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_exp   <= n_exp;
            r_dup   <= n_dup;
            r_rej   <= n_rej;
            r_esc   <= n_esc;
            r_check <= n_check;
            r_kind  <= n_kind;
        end
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = i_fire ? cnt : 2'd0;

endmodule
`default_nettype wire

>>> rtl/core/ifr_out_queue.sv
`default_nettype none
module ifr_out_queue
    import ifr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_result    i_res0,
    input  wire t_result    i_res1,
    input  wire logic [1:0] i_count,
    output logic            o_room,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_res
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;
    logic [QPTR_W-1:0] wr_next;

    assign pop     = o_valid & i_ready;
    assign wr_next = r_wr + QPTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_res   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr]    <= i_res0;
        if (i_count == 2'd2) r_mem[wr_next] <= i_res1;
    end

    always_comb begin
        n_cnt = r_cnt + QCNT_W'(i_count) - QCNT_W'(pop);
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(i_count);
            if (pop) r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire
